// File: rtl/core/blumt_pkg.sv
// Package for the Blum integer test block: widths, sequencer states and
// the request/response structs of the shared remainder unit.
// No dependencies.
package blumt_pkg;

	localparam int NUM_WIDTH = 16;
	localparam int DIV_W     = NUM_WIDTH / 2 + 1;
	localparam int SQ_W      = NUM_WIDTH + 2;
	localparam int CNT_W     = $clog2(NUM_WIDTH + 1);
	localparam int FACTOR_W  = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_EVAL,
		ST_DONE
	} state_t;

	typedef enum logic {
		PH_FACTOR,
		PH_COFACTOR
	} phase_t;

	typedef struct packed {
		logic                 start;
		logic [NUM_WIDTH-1:0] dividend;
		logic [DIV_W-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [NUM_WIDTH-1:0] quotient;
		logic [DIV_W-1:0]     remainder;
	} div_rsp_t;

endpackage

// File: rtl/core/blumt_channels.sv
// Valid/ready channel interfaces for the number input and the result output.
// Depends on blumt_pkg.
interface blumt_in_if;
	logic                           valid;
	logic                           ready;
	logic [blumt_pkg::NUM_WIDTH-1:0] number;

	modport source(output valid, output number, input ready);
	modport sink(input valid, input number, output ready);
endinterface

interface blumt_out_if;
	logic                          valid;
	logic                          ready;
	logic                          is_blum;
	logic [blumt_pkg::FACTOR_W-1:0] small_factor;

	modport source(output valid, output is_blum, output small_factor, input ready);
	modport sink(input valid, input is_blum, input small_factor, output ready);
endinterface

// File: rtl/core/blumt_divider.sv
// Restoring divider that yields one quotient bit per cycle.
// Depends on blumt_pkg for widths and the request/response structs.
module blumt_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  blumt_pkg::div_req_t req,
	output blumt_pkg::div_rsp_t rsp
);

	logic                            busy_q;
	logic                            done_q;
	logic [blumt_pkg::CNT_W-1:0]     cnt_q;
	logic [blumt_pkg::NUM_WIDTH-1:0] quot_q;
	logic [blumt_pkg::DIV_W-1:0]     rem_q;
	logic [blumt_pkg::DIV_W-1:0]     divisor_q;
	logic [blumt_pkg::DIV_W:0]       trial;
	logic [blumt_pkg::DIV_W:0]       diff;
	logic                            fits;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q, quot_q[blumt_pkg::NUM_WIDTH-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= blumt_pkg::CNT_W'(blumt_pkg::NUM_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == blumt_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q    <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[blumt_pkg::NUM_WIDTH-2:0], fits};
			rem_q  <= fits ? diff[blumt_pkg::DIV_W-1:0] : trial[blumt_pkg::DIV_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quot_q;
	assign rsp.remainder = rem_q;

endmodule

// File: rtl/core/blum_integer_test_top.sv
// Top level of the Blum integer test: sequencer, trial-division datapath
// and output register. Depends on blumt_pkg, blumt_channels, blumt_divider.
//
// Usage: one number arrives per transfer on in_ch; for each one exactly one
// result transfer leaves on out_ch carrying is_blum and small_factor (the
// smaller prime p, or 0 when the number is not a Blum integer).
// The block factors by trial division. Candidate divisors d run upward from
// 2 while d*d does not exceed the value; d*d is kept incrementally, so no
// multiplier is needed. Every trial uses the one shared restoring divider,
// which delivers one quotient bit per cycle; a trial passes through the
// check state, the divider's shift-and-subtract steps, its done strobe and
// the evaluation state. Once the least divisor p is found, the cofactor q is
// tested for primality with further trials starting again at p.
// The block works on one number at a time: in_ch.ready is high only while
// the sequencer is idle. Results wait in an output register; if the
// receiver stalls, the finished result holds there, and the sequencer can
// still take the next number and work on it until its own result is ready.
// Reset (arst_n low) empties the output register and returns the sequencer
// to idle; no other state needs clearing.
module blum_integer_test_top (
	input  logic        clk,
	input  logic        arst_n,
	blumt_in_if.sink    in_ch,
	blumt_out_if.source out_ch
);

	blumt_pkg::state_t state_q;
	blumt_pkg::state_t state_d;
	blumt_pkg::phase_t phase_q;

	logic [blumt_pkg::NUM_WIDTH-1:0] n_q;
	logic [blumt_pkg::NUM_WIDTH-1:0] v_q;
	logic [blumt_pkg::DIV_W-1:0]     d_q;
	logic [blumt_pkg::DIV_W-1:0]     p_q;
	logic [blumt_pkg::SQ_W-1:0]      sq_q;
	logic                            blum_q;

	logic                            out_valid_q;
	logic                            out_blum_q;
	logic [blumt_pkg::FACTOR_W-1:0]  out_factor_q;

	blumt_pkg::div_req_t div_req;
	blumt_pkg::div_rsp_t div_rsp;

	logic in_xfer;
	logic out_free;
	logic loop_end;
	logic rem_zero;
	logic factor_ok;

	blumt_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	// The trial loop stops once d*d exceeds the value under test.
	assign loop_end = sq_q > blumt_pkg::SQ_W'(v_q);
	assign rem_zero = div_rsp.remainder == '0;
	// The least divisor must lie strictly below sqrt(n), and both factors
	// must be 3 mod 4.
	assign factor_ok = (sq_q < blumt_pkg::SQ_W'(n_q)) && (d_q[1:0] == 2'b11)
		&& (div_rsp.quotient[1:0] == 2'b11);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			blumt_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (in_ch.number < blumt_pkg::NUM_WIDTH'(2)) begin
						state_d = blumt_pkg::ST_DONE;
					end else begin
						state_d = blumt_pkg::ST_CHECK;
					end
				end
			end
			blumt_pkg::ST_CHECK: begin
				state_d = loop_end ? blumt_pkg::ST_DONE : blumt_pkg::ST_DIV;
			end
			blumt_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = blumt_pkg::ST_EVAL;
				end
			end
			blumt_pkg::ST_EVAL: begin
				if (rem_zero && (phase_q == blumt_pkg::PH_COFACTOR || !factor_ok)) begin
					state_d = blumt_pkg::ST_DONE;
				end else begin
					state_d = blumt_pkg::ST_CHECK;
				end
			end
			blumt_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = blumt_pkg::ST_IDLE;
				end
			end
			default: state_d = blumt_pkg::ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_ch.ready          = 1'b0;
		div_req.start        = 1'b0;
		div_req.dividend     = v_q;
		div_req.divisor      = d_q;
		case (state_q)
			blumt_pkg::ST_IDLE:  in_ch.ready   = 1'b1;
			blumt_pkg::ST_CHECK: div_req.start = !loop_end;
			default: begin
				in_ch.ready   = 1'b0;
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blumt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Trial-division datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			blumt_pkg::ST_IDLE: begin
				if (in_xfer) begin
					n_q     <= in_ch.number;
					v_q     <= in_ch.number;
					d_q     <= blumt_pkg::DIV_W'(2);
					sq_q    <= blumt_pkg::SQ_W'(4);
					phase_q <= blumt_pkg::PH_FACTOR;
					blum_q  <= 1'b0;
				end
			end
			blumt_pkg::ST_CHECK: begin
				// No divisor left: a prime cofactor completes a Blum integer,
				// while a prime input number is rejected.
				if (loop_end) begin
					blum_q <= phase_q == blumt_pkg::PH_COFACTOR;
				end
			end
			blumt_pkg::ST_EVAL: begin
				if (rem_zero) begin
					if (phase_q == blumt_pkg::PH_FACTOR && factor_ok) begin
						// Cofactor test starts at p: any divisor of q is at least p.
						phase_q <= blumt_pkg::PH_COFACTOR;
						v_q     <= div_rsp.quotient;
						p_q     <= d_q;
					end
				end else begin
					sq_q <= sq_q + blumt_pkg::SQ_W'({d_q, 1'b1});
					d_q  <= d_q + 1'b1;
				end
			end
			default: begin
				blum_q <= blum_q;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == blumt_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == blumt_pkg::ST_DONE && out_free) begin
			out_blum_q   <= blum_q;
			out_factor_q <= blum_q ? p_q[blumt_pkg::FACTOR_W-1:0] : '0;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.is_blum      = out_blum_q;
	assign out_ch.small_factor = out_factor_q;

endmodule
